FILE: rtl/u8d_pkg.sv
// shared types and constants for the utf-8 code point decoder
// no dependencies; imported by every module of the block

package u8d_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] QMARK      = 21'h00003F;
    localparam logic [CP_W-1:0] WIDE_LIMIT = 21'h010000;

    // result queue: deep enough that one decoded byte (two results) always fits
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_CONT  = 3'd1,
        CLS_LEAD2 = 3'd2,
        CLS_LEAD3 = 3'd3,
        CLS_LEAD4 = 3'd4,
        CLS_BAD   = 3'd5
    } byte_class_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            substituted;
        logic            last;
    } result_t;

    typedef struct packed {
        result_t         res0;
        result_t         res1;
        logic [1:0]      count;
        logic [1:0]      pend_next;
        logic [CP_W-1:0] partial_next;
    } decode_t;

endpackage

FILE: rtl/u8d_decode.sv
// combinational decode of one registered byte against the sequence state
// depends on u8d_pkg

module u8d_decode
    import u8d_pkg::*;
(
    input  logic [7:0]      byte_in,
    input  logic            end_of_text,
    input  logic            narrow_chars,
    input  logic [1:0]      pend,
    input  logic [CP_W-1:0] partial,
    output decode_t         dec
);

    byte_class_t     cls;
    logic            broken;
    logic            extend;
    logic            flush;
    logic            main_valid;
    logic [CP_W-1:0] main_cp;
    logic            main_sub;
    logic [CP_W-1:0] cont_bits;
    logic [CP_W-1:0] merged;
    logic [1:0]      pend_n;
    logic [CP_W-1:0] partial_n;
    result_t         qres;
    result_t         mres;

    always_comb
    begin
        if (byte_in inside {[8'h00:8'h7F]})
            cls = CLS_ASCII;
        else if (byte_in inside {[8'h80:8'hBF]})
            cls = CLS_CONT;
        else if (byte_in inside {[8'hC0:8'hDF]})
            cls = CLS_LEAD2;
        else if (byte_in inside {[8'hE0:8'hEF]})
            cls = CLS_LEAD3;
        else if (byte_in inside {[8'hF0:8'hF7]})
            cls = CLS_LEAD4;
        else
            cls = CLS_BAD;
    end

    assign cont_bits = {{(CP_W-6){1'b0}}, byte_in[5:0]};

    // six payload bits land above the ones still due
    always_comb
    begin
        case (pend)
            2'd3:    merged = partial | (cont_bits << 12);
            2'd2:    merged = partial | (cont_bits << 6);
            default: merged = partial | cont_bits;
        endcase
    end

    assign broken = (pend != 2'd0) && (cls != CLS_CONT);
    assign extend = (pend != 2'd0) && (cls == CLS_CONT);

    always_comb
    begin
        main_valid = 1'b0;
        main_cp    = QMARK;
        main_sub   = 1'b1;
        pend_n     = 2'd0;
        partial_n  = '0;
        if (extend)
        begin
            pend_n = pend - 2'd1;
            if (pend_n == 2'd0)
            begin
                main_valid = 1'b1;
                if (!(narrow_chars && (merged >= WIDE_LIMIT)))
                begin
                    main_cp  = merged;
                    main_sub = 1'b0;
                end
            end
            else
            begin
                partial_n = merged;
            end
        end
        else
        begin
            // fresh lead byte, also after a broken sequence
            case (cls)
                CLS_ASCII:
                begin
                    main_valid = 1'b1;
                    main_cp    = {{(CP_W-8){1'b0}}, byte_in};
                    main_sub   = 1'b0;
                end
                CLS_LEAD2:
                begin
                    pend_n    = 2'd1;
                    partial_n = {10'b0, byte_in[4:0], 6'b0};
                end
                CLS_LEAD3:
                begin
                    pend_n    = 2'd2;
                    partial_n = {5'b0, byte_in[3:0], 12'b0};
                end
                CLS_LEAD4:
                begin
                    pend_n    = 2'd3;
                    partial_n = {byte_in[2:0], 18'b0};
                end
                default:
                begin
                    main_valid = 1'b1;
                end
            endcase
        end
    end

    assign flush = end_of_text && (pend_n != 2'd0);

    assign qres = '{code_point: QMARK, substituted: 1'b1, last: 1'b0};
    assign mres = '{code_point: main_cp, substituted: main_sub, last: 1'b0};

    // at most two of broken, main and flush occur together
    always_comb
    begin
        dec.count = {1'b0, broken} + {1'b0, main_valid} + {1'b0, flush};
        dec.res0  = broken ? qres : (main_valid ? mres : qres);
        dec.res1  = (broken && main_valid) ? mres : qres;
        dec.res0.last = (dec.count == 2'd1);
        dec.res1.last = 1'b1;
        dec.pend_next    = flush ? 2'd0 : pend_n;
        dec.partial_next = flush ? '0 : partial_n;
    end

endmodule

FILE: rtl/u8d_result_fifo.sv
// small result queue taking up to two results per cycle, one out per beat
// depends on u8d_pkg

module u8d_result_fifo
    import u8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  result_t    push0,
    input  result_t    push1,
    input  logic       pop,
    output result_t    head,
    output logic       not_empty,
    output logic       room2
);

    result_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   cnt_reg;
    logic [FIFO_AW:0]   cnt_next;
    logic [FIFO_AW-1:0] wr_ptr_p1;

    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign not_empty = (cnt_reg != '0);
    assign room2     = (cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign head      = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign cnt_next    = cnt_reg + (FIFO_AW+1)'(push_cnt) - (FIFO_AW+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            mem_reg[wr_ptr_p1] <= push1;
    end

endmodule

FILE: rtl/utf8_code_point_decoder.sv
// top level of the utf-8 code point decoder: input register, decode, result queue
// depends on u8d_pkg, u8d_decode, u8d_result_fifo
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, byte_in, end_of_text   | sink
//  out     | out_valid/out_ready, code_point,          | source
//          | substituted, last                         |
//  cfg     | cfg_wr_en, cfg_wr_data (narrow_chars)     | write only
//
// one byte accepted per cycle while the queue has two slots free; a byte is decoded
// from the input register and its results are written to the queue that feeds the out port
// a byte giving two results holds the out port for two beats; the four-entry
// result queue sets when input stalls (it takes a byte only with two slots free)
// reset clears the sequence state, the queue and narrow_chars; no clearing pass
// stalls on out back up through the queue to in_ready, nothing is dropped

module utf8_code_point_decoder
    import u8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      byte_in,
    input  logic            end_of_text,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [CP_W-1:0] code_point,
    output logic            substituted,
    output logic            last,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data
);

    logic            in_valid_reg;
    logic [7:0]      byte_reg;
    logic            eot_reg;
    logic [1:0]      pend_reg;
    logic [CP_W-1:0] partial_reg;
    logic            narrow_reg;
    logic            consume;
    logic            room2;
    logic            pop;
    logic [1:0]      push_cnt;
    decode_t         dec;
    result_t         head;

    assign consume  = in_valid_reg && room2;
    assign in_ready = !in_valid_reg || consume;
    assign pop      = out_valid && out_ready;
    assign push_cnt = consume ? dec.count : 2'd0;

    u8d_decode u_decode (
        .byte_in      (byte_reg),
        .end_of_text  (eot_reg),
        .narrow_chars (narrow_reg),
        .pend         (pend_reg),
        .partial      (partial_reg),
        .dec          (dec)
    );

    u8d_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (dec.res0),
        .push1     (dec.res1),
        .pop       (pop),
        .head      (head),
        .not_empty (out_valid),
        .room2     (room2)
    );

    assign code_point  = head.code_point;
    assign substituted = head.substituted;
    assign last        = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pend_reg     <= 2'd0;
            partial_reg  <= '0;
            narrow_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (consume)
            begin
                pend_reg    <= dec.pend_next;
                partial_reg <= dec.partial_next;
            end
            if (cfg_wr_en)
                narrow_reg <= cfg_wr_data;
        end
    end

    // input beat register, payload only
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= byte_in;
            eot_reg  <= end_of_text;
        end
    end

endmodule

FILE: rtl/u8d_checker.sv
// port-level checks for the utf-8 code point decoder, bound to the top level
// depends on u8d_pkg and utf8_code_point_decoder

module u8d_checker
    import u8d_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_ready,
    input logic [CP_W-1:0] code_point,
    input logic            substituted,
    input logic            cfg_wr_en,
    input logic            cfg_wr_data
);

    logic narrow_reg;

    // own copy of the mode bit as seen on the cfg port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            narrow_reg <= 1'b0;
        else if (cfg_wr_en)
            narrow_reg <= cfg_wr_data;
    end

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point)
            && $stable(substituted))
        else $error("stalled result changed");

    a_sub_is_qmark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && substituted |-> code_point == QMARK)
        else $error("replacement result is not a question mark");

    a_narrow_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && narrow_reg && !substituted |-> code_point < WIDE_LIMIT)
        else $error("wide code point in narrow mode");

endmodule

bind utf8_code_point_decoder u8d_checker u_u8d_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .substituted (substituted),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
);

FILE: bench/utf8_code_point_decoder_tb.sv
// testbench for utf8_code_point_decoder: directed and random byte streams, with
// code points predicted in-bench and checked beat by beat on the out port
// depends on u8d_pkg (CP_W, QMARK, WIDE_LIMIT, result_t) and the rtl top level
`timescale 1ns / 1ps

module utf8_code_point_decoder_tb;
    import u8d_pkg::*;

    logic            clk         = 1'b0;
    logic            rst_n;
    logic            in_valid    = 1'b0;
    logic            in_ready;
    logic [7:0]      byte_in     = 8'h00;
    logic            end_of_text = 1'b0;
    logic            out_valid;
    logic            out_ready   = 1'b0;
    logic [CP_W-1:0] code_point;
    logic            substituted;
    logic            last;
    logic            cfg_wr_en   = 1'b0;
    logic            cfg_wr_data = 1'b0;

    // decoder state as the bench sees it
    logic [1:0]      seq_left    = 2'd0;
    logic [CP_W-1:0] seq_value   = '0;
    logic            narrow_mode = 1'b0;

    result_t         step_out [0:2];
    int              step_n;
    result_t         expected_chars [$];

    logic            no_gaps     = 1'b0;
    int              errors      = 0;
    int              bytes_sent  = 0;
    int              chars_seen  = 0;
    int              subs_seen   = 0;

    utf8_code_point_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_in     (byte_in),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .substituted (substituted),
        .last        (last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= no_gaps || ($urandom_range(0, 99) >= 7);
    end

    task automatic add_char(input logic [CP_W-1:0] cp, input logic sub);
        step_out[step_n] = '{code_point: cp, substituted: sub, last: 1'b0};
        step_n++;
    endtask

    task automatic open_lead(input logic [7:0] b);
        if (b[7] == 1'b0)
        begin
            add_char(CP_W'(b), 1'b0);
        end
        else if (b[7:5] == 3'b110)
        begin
            seq_value = CP_W'(b[4:0]) << 6;
            seq_left  = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            seq_value = CP_W'(b[3:0]) << 12;
            seq_left  = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            seq_value = CP_W'(b[2:0]) << 18;
            seq_left  = 2'd3;
        end
        else
        begin
            add_char(QMARK, 1'b1);
        end
    endtask

    // expected characters for one accepted byte
    task automatic predict_chars(input logic [7:0] b, input logic eot);
        int sh;
        step_n = 0;
        if (seq_left != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                sh        = 6 * (int'(seq_left) - 1);
                seq_value = seq_value | (CP_W'(b[5:0]) << sh);
                seq_left  = seq_left - 2'd1;
                if (seq_left == 2'd0)
                begin
                    if (narrow_mode && seq_value >= WIDE_LIMIT)
                        add_char(QMARK, 1'b1);
                    else
                        add_char(seq_value, 1'b0);
                    seq_value = '0;
                end
            end
            else
            begin
                // broken sequence, then the byte starts over as a lead
                add_char(QMARK, 1'b1);
                seq_left  = 2'd0;
                seq_value = '0;
                open_lead(b);
            end
        end
        else
        begin
            open_lead(b);
        end
        if (eot && seq_left != 2'd0)
        begin
            add_char(QMARK, 1'b1);
            seq_left  = 2'd0;
            seq_value = '0;
        end
        if (step_n > 0)
            step_out[step_n-1].last = 1'b1;
        for (int k = 0; k < step_n; k++)
            expected_chars.push_back(step_out[k]);
    endtask

    always @(posedge clk)
    begin : check_chars
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            chars_seen++;
            if (substituted)
                subs_seen++;
            if (expected_chars.size() == 0)
            begin
                $error("unexpected beat: code_point %h substituted %b last %b",
                       code_point, substituted, last);
                errors++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (code_point !== want.code_point)
                begin
                    $error("code_point: expected %h, got %h", want.code_point, code_point);
                    errors++;
                end
                if (substituted !== want.substituted)
                begin
                    $error("substituted: expected %b, got %b", want.substituted, substituted);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, last);
                    errors++;
                end
            end
        end
    end

    // valid stays high across back-to-back beats; only gaps drop it
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while (!no_gaps && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        byte_in     <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_chars(b, eot);
        bytes_sent++;
    endtask

    // stop sending, let every expected beat arrive, then let the pipeline settle
    task automatic drain_output();
        int waited;
        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (expected_chars.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_chars.size() != 0)
        begin
            $error("%0d expected characters never arrived", expected_chars.size());
            errors++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic set_narrow(input logic value);
        drain_output();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        narrow_mode  = value;
    endtask

    task automatic test_ascii();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_multibyte_wide();
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_bad_bytes();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF8, 1'b0);
    endtask

    task automatic test_broken_sequences();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        // broken lead followed by a new lead that the end mark flushes
        send_byte(8'hC3, 1'b0);
        send_byte(8'hE2, 1'b1);
    endtask

    task automatic test_end_flush();
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b1);
    endtask

    task automatic test_narrow_mode();
        set_narrow(1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    // mostly well-formed sequences, some noise bytes and cut-short sequences
    task automatic send_random_text(input int byte_budget);
        logic [7:0] seq [0:3];
        int         len;
        int         keep;
        int         pick;
        int         sent;
        logic       eot;
        sent = 0;
        while (sent < byte_budget)
        begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(1, 4);
            case (len)
                1:       seq[0] = {1'b0, 7'($urandom)};
                2:       seq[0] = {3'b110, 5'($urandom)};
                3:       seq[0] = {4'b1110, 4'($urandom)};
                default: seq[0] = {5'b11110, 3'($urandom)};
            endcase
            for (int k = 1; k < 4; k++)
                seq[k] = {2'b10, 6'($urandom)};
            keep = len;
            if (pick < 12)
            begin
                seq[0] = 8'($urandom);
                keep   = 1;
            end
            else if (pick < 24 && len > 1)
            begin
                keep = $urandom_range(1, len - 1);
            end
            for (int k = 0; k < keep; k++)
            begin
                eot = (k == keep - 1) ? ($urandom_range(0, 99) < 8)
                                      : ($urandom_range(0, 99) < 3);
                send_byte(seq[k], eot);
                sent++;
            end
        end
    endtask

    task automatic test_random_text();
        set_narrow(1'b0);
        send_random_text(150);
        set_narrow(1'b1);
        send_random_text(50);
        no_gaps = 1'b1;
        send_random_text(100);
        no_gaps = 1'b0;
        set_narrow(1'b0);
        send_random_text(100);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ascii();
        test_multibyte_wide();
        test_bad_bytes();
        test_broken_sequences();
        test_end_flush();
        test_narrow_mode();
        test_random_text();
        drain_output();
        $display("sent %0d bytes in both character widths; checked %0d characters, %0d of them",
                 bytes_sent, chars_seen, subs_seen);
        $display("  replacements, across bad leads, stray and broken sequences and end flushes");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule
